// ----- hdl/i2cbm_pkg.sv -----
// Shared types and constants for the I2C bit-level master.
`timescale 1ns / 1ps
`default_nettype none
package i2cbm_pkg;

	localparam int DELAY_BITS_DEF = 16;
	localparam int HP_W           = 16;
	localparam logic [HP_W-1:0] HP_RESET = 16'd255;

	localparam int IN_DATA_W  = 16;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 16;

	localparam int QDEPTH = 2;
	localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCW    = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_STOP  = 2'd1,
		OP_WRITE = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		PH_IDLE        = 4'd0,
		PH_START_A     = 4'd1,
		PH_START_B     = 4'd2,
		PH_STOP_A      = 4'd3,
		PH_STOP_B      = 4'd4,
		PH_WR_DATA     = 4'd5,
		PH_WR_HIGH     = 4'd6,
		PH_WR_ACK_LOW  = 4'd7,
		PH_WR_ACK_HIGH = 4'd8,
		PH_RD_HIGH     = 4'd9,
		PH_RD_LOW      = 4'd10,
		PH_RD_ACK_LOW  = 4'd11,
		PH_RD_ACK_HIGH = 4'd12
	} phase_t;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	typedef struct packed {
		logic       cmd_valid;
		op_t        opcode;
		logic [7:0] write_byte;
		logic       ack_to_send;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic       ack_seen;
		logic [7:0] read_byte;
		logic       done_res;
		logic       busy_res;
		logic       sda_out;
		logic       scl_out;
	} res_t;

endpackage
`default_nettype wire

// ----- hdl/i2cbm_front.sv -----
// Input side: unpacks stream words into commands and queues them for the bit engine.
`timescale 1ns / 1ps
`default_nettype none
module i2cbm_front (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  wire logic [i2cbm_pkg::IN_DATA_W-1:0] s_axis_tdata,
	input  wire logic [i2cbm_pkg::IN_USER_W-1:0] s_axis_tuser,
	output logic                                  q_valid,
	output i2cbm_pkg::item_t                      q_item,
	input  wire logic                             q_pop
);

	i2cbm_pkg::item_t                fifo_q [i2cbm_pkg::QDEPTH];
	logic [i2cbm_pkg::QAW-1:0]       wr_ptr_q;
	logic [i2cbm_pkg::QAW-1:0]       rd_ptr_q;
	logic [i2cbm_pkg::QCW-1:0]       count_q;
	i2cbm_pkg::item_t                in_item;
	logic                            push;
	logic                            pop;

	always_comb begin
		in_item.cmd_valid   = s_axis_tuser[0];
		in_item.opcode      = i2cbm_pkg::op_t'(s_axis_tuser[2:1]);
		in_item.write_byte  = s_axis_tdata[7:0];
		in_item.ack_to_send = s_axis_tdata[8];
		in_item.sda_in      = s_axis_tdata[9];
	end

	assign s_axis_tready = (count_q != i2cbm_pkg::QCW'(i2cbm_pkg::QDEPTH));
	assign push          = s_axis_tvalid && s_axis_tready;
	assign q_valid       = (count_q != '0);
	assign pop           = q_pop && q_valid;
	assign q_item        = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == i2cbm_pkg::QAW'(i2cbm_pkg::QDEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == i2cbm_pkg::QAW'(i2cbm_pkg::QDEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= i2cbm_pkg::QCW'(i2cbm_pkg::QDEPTH))
		else $error("queue count out of range");

endmodule
`default_nettype wire

// ----- hdl/i2cbm_engine.sv -----
// Bit engine: steps the I2C pin sequencer once per queued word and registers the result.
`timescale 1ns / 1ps
`default_nettype none
module i2cbm_engine #(
	parameter int DELAY_BITS = i2cbm_pkg::DELAY_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [i2cbm_pkg::HP_W-1:0]       cfg_wdata,
	input  wire logic                              q_valid,
	input  wire i2cbm_pkg::item_t                  q_item,
	output logic                                   q_pop,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	output logic [i2cbm_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

	localparam int CW = (DELAY_BITS > i2cbm_pkg::HP_W) ? DELAY_BITS : i2cbm_pkg::HP_W;

	logic [i2cbm_pkg::HP_W-1:0] half_period_q;
	i2cbm_pkg::phase_t          phase_q, phase_d;
	logic [DELAY_BITS-1:0]      dly_q, dly_d, dly_dec, dly_load;
	logic [3:0]                 bit_idx_q, bit_idx_d, bit_inc;
	logic [7:0]                 shift_q, shift_d, shift_up;
	logic                       scl_q, scl_d;
	logic                       sda_q, sda_d;
	logic                       ack_q, ack_d;
	logic                       ack_lvl_q, ack_lvl_d;
	logic [7:0]                 read_hold_q, read_hold_d;
	logic                       done_d;
	logic                       fire;
	logic                       out_valid_q;
	i2cbm_pkg::res_t            res_d;
	i2cbm_pkg::res_t            res_q;
	logic [CW-1:0]              hp_ext;
	logic [CW-1:0]              cap_ext;

	assign hp_ext  = CW'(half_period_q);
	assign cap_ext = CW'({DELAY_BITS{1'b1}});

	always_comb begin
		if (half_period_q == '0) begin
			dly_load = DELAY_BITS'(1);
		end else if (hp_ext > cap_ext) begin
			dly_load = {DELAY_BITS{1'b1}};
		end else begin
			dly_load = DELAY_BITS'(hp_ext);
		end
	end

	assign fire  = q_valid && (!out_valid_q || m_axis_tready);
	assign q_pop = fire;

	assign dly_dec  = (dly_q != '0) ? dly_q - 1'b1 : dly_q;
	assign bit_inc  = bit_idx_q + 1'b1;
	assign shift_up = {shift_q[6:0], 1'b0};

	always_comb begin
		phase_d     = phase_q;
		dly_d       = dly_q;
		bit_idx_d   = bit_idx_q;
		shift_d     = shift_q;
		scl_d       = scl_q;
		sda_d       = sda_q;
		ack_d       = ack_q;
		ack_lvl_d   = ack_lvl_q;
		read_hold_d = read_hold_q;
		done_d      = 1'b0;

		if (phase_q == i2cbm_pkg::PH_IDLE) begin
			if (q_item.cmd_valid) begin
				ack_lvl_d = q_item.ack_to_send;
				bit_idx_d = '0;
				dly_d     = dly_load;
				case (q_item.opcode)
					i2cbm_pkg::OP_START: begin
						sda_d   = 1'b1;
						scl_d   = 1'b1;
						phase_d = i2cbm_pkg::PH_START_A;
					end
					i2cbm_pkg::OP_STOP: begin
						sda_d   = 1'b0;
						scl_d   = 1'b1;
						phase_d = i2cbm_pkg::PH_STOP_A;
					end
					i2cbm_pkg::OP_WRITE: begin
						shift_d = q_item.write_byte;
						sda_d   = q_item.write_byte[7];
						phase_d = i2cbm_pkg::PH_WR_DATA;
					end
					default: begin
						shift_d = '0;
						sda_d   = 1'b1;
						scl_d   = 1'b1;
						phase_d = i2cbm_pkg::PH_RD_HIGH;
					end
				endcase
			end
		end else begin
			dly_d = dly_dec;
			if (dly_dec == '0) begin
				dly_d = dly_load;
				case (phase_q)
					i2cbm_pkg::PH_START_A: begin
						sda_d   = 1'b0;
						phase_d = i2cbm_pkg::PH_START_B;
					end
					i2cbm_pkg::PH_START_B: begin
						scl_d  = 1'b0;
						done_d = 1'b1;
					end
					i2cbm_pkg::PH_STOP_A: begin
						sda_d   = 1'b1;
						phase_d = i2cbm_pkg::PH_STOP_B;
					end
					i2cbm_pkg::PH_STOP_B: begin
						done_d = 1'b1;
					end
					i2cbm_pkg::PH_WR_DATA: begin
						scl_d   = 1'b1;
						phase_d = i2cbm_pkg::PH_WR_HIGH;
					end
					i2cbm_pkg::PH_WR_HIGH: begin
						scl_d     = 1'b0;
						shift_d   = shift_up;
						bit_idx_d = bit_inc;
						if (bit_inc >= i2cbm_pkg::BITS_PER_BYTE) begin
							sda_d   = 1'b1;
							phase_d = i2cbm_pkg::PH_WR_ACK_LOW;
						end else begin
							sda_d   = shift_up[7];
							phase_d = i2cbm_pkg::PH_WR_DATA;
						end
					end
					i2cbm_pkg::PH_WR_ACK_LOW: begin
						scl_d   = 1'b1;
						phase_d = i2cbm_pkg::PH_WR_ACK_HIGH;
					end
					i2cbm_pkg::PH_WR_ACK_HIGH: begin
						ack_d  = q_item.sda_in;
						scl_d  = 1'b0;
						done_d = 1'b1;
					end
					i2cbm_pkg::PH_RD_HIGH: begin
						shift_d   = {shift_q[6:0], q_item.sda_in};
						scl_d     = 1'b0;
						bit_idx_d = bit_inc;
						phase_d   = i2cbm_pkg::PH_RD_LOW;
					end
					i2cbm_pkg::PH_RD_LOW: begin
						if (bit_idx_q >= i2cbm_pkg::BITS_PER_BYTE) begin
							sda_d   = ack_lvl_q;
							phase_d = i2cbm_pkg::PH_RD_ACK_LOW;
						end else begin
							scl_d   = 1'b1;
							phase_d = i2cbm_pkg::PH_RD_HIGH;
						end
					end
					i2cbm_pkg::PH_RD_ACK_LOW: begin
						scl_d   = 1'b1;
						phase_d = i2cbm_pkg::PH_RD_ACK_HIGH;
					end
					i2cbm_pkg::PH_RD_ACK_HIGH: begin
						scl_d       = 1'b0;
						read_hold_d = shift_q;
						done_d      = 1'b1;
					end
					default: begin
						dly_d   = dly_dec;
						phase_d = i2cbm_pkg::PH_IDLE;
					end
				endcase
				if (done_d) begin
					dly_d   = dly_dec;
					phase_d = i2cbm_pkg::PH_IDLE;
				end
			end
		end

		res_d.scl_out   = scl_d;
		res_d.sda_out   = sda_d;
		res_d.busy_res  = (phase_d != i2cbm_pkg::PH_IDLE);
		res_d.done_res  = done_d;
		res_d.read_byte = read_hold_d;
		res_d.ack_seen  = ack_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= i2cbm_pkg::HP_RESET;
		end else if (cfg_we) begin
			half_period_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= i2cbm_pkg::PH_IDLE;
			dly_q       <= '0;
			bit_idx_q   <= '0;
			shift_q     <= '0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			ack_q       <= 1'b1;
			ack_lvl_q   <= 1'b0;
			read_hold_q <= '0;
		end else if (fire) begin
			phase_q     <= phase_d;
			dly_q       <= dly_d;
			bit_idx_q   <= bit_idx_d;
			shift_q     <= shift_d;
			scl_q       <= scl_d;
			sda_q       <= sda_d;
			ack_q       <= ack_d;
			ack_lvl_q   <= ack_lvl_d;
			read_hold_q <= read_hold_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = i2cbm_pkg::OUT_DATA_W'(res_q);

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res_d.done_res |-> !res_d.busy_res)
		else $error("command completed while still busy");

	a_active_delay: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != i2cbm_pkg::PH_IDLE |-> dly_q != '0)
		else $error("active phase with empty delay counter");

	a_bit_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_idx_q <= i2cbm_pkg::BITS_PER_BYTE)
		else $error("bit index beyond one byte");

	a_hold_idle_state: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(phase_q) && $stable(dly_q))
		else $error("engine state moved without a word");

endmodule
`default_nettype wire

// ----- hdl/i2c_bit_level_master_top.sv -----
// Top level of the I2C bit-level master: command queue front and bit engine back.
// Path: an accepted word is written into the front queue, then stepped by the engine into its m_axis result register.
// Throughput: one word per cycle unless m_axis back-pressure stalls the engine; each word is
// one tick of the bit engine, a single step through the pin sequencer.
// Reset (arst_n low): queue and output emptied, engine idle with SCL and SDA released,
// read byte 0, acknowledge seen 1, half period 255.
`timescale 1ns / 1ps
`default_nettype none
module i2c_bit_level_master_top #(
	parameter int DELAY_BITS = i2cbm_pkg::DELAY_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [i2cbm_pkg::HP_W-1:0]       cfg_wdata,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// write_byte[7:0], ack_to_send[8], sda_in[9], zero[15:10]
	input  wire logic [i2cbm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// cmd_valid[0], opcode[2:1]
	input  wire logic [i2cbm_pkg::IN_USER_W-1:0]  s_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// scl_out[0], sda_out[1], busy_res[2], done_res[3], read_byte[11:4], ack_seen[12],
	// zero[15:13]
	output logic [i2cbm_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

	logic             q_valid;
	logic             q_pop;
	i2cbm_pkg::item_t q_item;

	i2cbm_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop)
	);

	i2cbm_engine #(
		.DELAY_BITS (DELAY_BITS)
	) u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule
`default_nettype wire
